// ----- src/tgr_pkg.sv -----
// ----------------------------------------------------------------------------
// tgr_pkg
// Shared types, constants and the color palette for the text glyph rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package tgr_pkg;

  // Limits of the character cell and the text screen.
  localparam int MAX_GLYPH_WIDTH  = 16;
  localparam int MAX_GLYPH_HEIGHT = 32;
  localparam int FONT_CHARS       = 256;
  localparam int TEXT_ROWS        = 64;
  localparam int TEXT_COLS        = 128;

  // Field widths.
  localparam int GW_W      = 5;   // glyph width register
  localparam int GH_W      = 6;   // glyph height register
  localparam int FONT_AW   = 14;  // font store byte address
  localparam int BANK_AW   = FONT_AW - 1;
  localparam int ROW_W     = 6;
  localparam int COL_W     = 7;
  localparam int PIX_W     = 11;
  localparam int RGB_W     = 24;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 6;

  // Command queue between front and back.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GLYPH_WIDTH  = 1'b0,
    CFG_GLYPH_HEIGHT = 1'b1
  } tgr_cfg_idx_t;

  // Input item function codes.
  localparam logic FUNC_FONT_WRITE = 1'b0;
  localparam logic FUNC_RENDER     = 1'b1;

  // Command kinds carried by the queue.
  typedef enum logic {
    CMD_FONT_WRITE = 1'b0,
    CMD_RENDER     = 1'b1
  } tgr_cmd_kind_t;

  typedef struct packed {
    logic              func;
    logic [FONT_AW-1:0] font_address;
    logic [7:0]        font_byte;
    logic [ROW_W-1:0]  cell_row;
    logic [COL_W-1:0]  cell_col;
    logic [15:0]       char_attr;
  } tgr_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
    logic [15:0]      glyph_bits;
    logic [RGB_W-1:0] fg_rgb;
    logic [RGB_W-1:0] bg_rgb;
    logic             last_line;
  } tgr_out_t;

  // One classified command from the front to the back.
  typedef struct packed {
    tgr_cmd_kind_t      kind;
    logic [FONT_AW-1:0] font_addr;   // font write address
    logic [7:0]         font_byte;   // font write data
    logic [PIX_W-1:0]   pixel_x;     // col * W
    logic [PIX_W-1:0]   y_base;      // row * H
    logic [FONT_AW-1:0] glyph_addr;  // address of the first byte of line 0
    logic               wide;        // two bytes per line
    logic [GH_W-1:0]    height;      // clamped H
    logic [3:0]         fg_idx;
    logic [3:0]         bg_idx;
  } tgr_cmd_t;

  // Fixed 16-entry palette (ANSI color order), 0xRRGGBB.
  function automatic logic [RGB_W-1:0] vga_color(input logic [3:0] idx);
    logic [RGB_W-1:0] c;
    case (idx)
      4'd0:    c = 24'h000000;
      4'd1:    c = 24'hAA0000;
      4'd2:    c = 24'h00AA00;
      4'd3:    c = 24'hAAAA00;
      4'd4:    c = 24'h0000AA;
      4'd5:    c = 24'hAA00AA;
      4'd6:    c = 24'h00AAAA;
      4'd7:    c = 24'hAAAAAA;
      4'd8:    c = 24'h555555;
      4'd9:    c = 24'hFF5555;
      4'd10:   c = 24'h55FF55;
      4'd11:   c = 24'hFFFF55;
      4'd12:   c = 24'h5555FF;
      4'd13:   c = 24'hFF55FF;
      4'd14:   c = 24'h55FFFF;
      default: c = 24'hFFFFFF;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- src/text_glyph_rasterizer.sv -----
// ----------------------------------------------------------------------------
// text_glyph_rasterizer
// Text console character generator: font store writes and per-scanline
// rendering of character cells.
// ----------------------------------------------------------------------------
// The block takes one input beat per cycle while its four-entry command queue
// has room. A font write beat stores one byte and gives no result; a render
// beat for an on-screen cell gives H result beats, one per glyph scanline,
// with the last one flagged; off-screen cells give nothing. The back end takes
// a command from the queue and then, while the read stage can move on, reads
// one scanline per cycle from the font memory (even and odd bytes in separate
// banks, so a two-byte line costs one read); it takes no new command until the
// last line of a render is read. Results flow through a read stage and an
// output register, so a stalled output halts the output register, the read
// stage and the line walker. The font store powers up with unknown contents;
// rendering a glyph whose bytes were never written gives unspecified glyph bits.
// Geometry registers may be written only while the block is idle.
`default_nettype none

module text_glyph_rasterizer
  import tgr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire tgr_in_t              in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output tgr_out_t                  out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_wdata
);

  logic     push;
  tgr_cmd_t push_data;
  logic     full;
  logic     pop;
  tgr_cmd_t pop_data;
  logic     empty;

  tgr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_push    (push),
    .q_data    (push_data),
    .q_full    (full)
  );

  tgr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  tgr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_pop     (pop),
    .q_data    (pop_data),
    .q_empty   (empty),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ----- src/tgr_front.sv -----
// ----------------------------------------------------------------------------
// tgr_front
// Holds the cell geometry registers, accepts input beats and turns each one
// into a font write or render command; off-screen cells are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module tgr_front
  import tgr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire tgr_in_t              in_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_wdata,
  output logic                      q_push,
  output tgr_cmd_t                  q_data,
  input  wire logic                 q_full
);

  logic [GW_W-1:0] glyph_width_r;
  logic [GH_W-1:0] glyph_height_r;
  logic [GW_W-1:0] w;
  logic [GH_W-1:0] h;
  logic            on_screen;
  logic            accept;
  logic [11:0]     px_prod;
  logic [11:0]     py_prod;
  logic [FONT_AW-1:0] ch_base;

  // Geometry registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      glyph_width_r  <= GW_W'(8);
      glyph_height_r <= GH_W'(16);
    end else if (cfg_we) begin
      case (tgr_cfg_idx_t'(cfg_index))
        CFG_GLYPH_WIDTH:  glyph_width_r  <= cfg_wdata[GW_W-1:0];
        CFG_GLYPH_HEIGHT: glyph_height_r <= cfg_wdata[GH_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the geometry into its legal range.
  always_comb begin
    if (glyph_width_r == '0) begin
      w = GW_W'(1);
    end else if (int'(glyph_width_r) > MAX_GLYPH_WIDTH) begin
      w = GW_W'(MAX_GLYPH_WIDTH);
    end else begin
      w = glyph_width_r;
    end
    if (glyph_height_r == '0) begin
      h = GH_W'(1);
    end else if (int'(glyph_height_r) > MAX_GLYPH_HEIGHT) begin
      h = GH_W'(MAX_GLYPH_HEIGHT);
    end else begin
      h = glyph_height_r;
    end
  end

  // Accept whenever the queue has room.
  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;
  assign on_screen = (int'(in_data.cell_row) < TEXT_ROWS) &&
                     (int'(in_data.cell_col) < TEXT_COLS);
  assign q_push    = accept && ((in_data.func == FUNC_FONT_WRITE) || on_screen);

  // Cell origin and glyph base address.
  assign px_prod = 12'(in_data.cell_col) * 12'(w);
  assign py_prod = 12'(in_data.cell_row) * 12'(h);
  assign ch_base = FONT_AW'(in_data.char_attr[7:0] & 8'(FONT_CHARS - 1)) * FONT_AW'(h);

  always_comb begin
    q_data.kind       = (in_data.func == FUNC_RENDER) ? CMD_RENDER : CMD_FONT_WRITE;
    q_data.font_addr  = in_data.font_address;
    q_data.font_byte  = in_data.font_byte;
    q_data.pixel_x    = px_prod[PIX_W-1:0];
    q_data.y_base     = py_prod[PIX_W-1:0];
    q_data.wide       = (w > GW_W'(8));
    q_data.glyph_addr = q_data.wide ? {ch_base[FONT_AW-2:0], 1'b0} : ch_base;
    q_data.height     = h;
    q_data.fg_idx     = in_data.char_attr[11:8];
    q_data.bg_idx     = in_data.char_attr[15:12];
  end

endmodule

`default_nettype wire

// ----- src/tgr_queue.sv -----
// ----------------------------------------------------------------------------
// tgr_queue
// Short command FIFO that decouples the front from the back.
// ----------------------------------------------------------------------------
`default_nettype none

module tgr_queue
  import tgr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire tgr_cmd_t push_data,
  output logic          full,
  input  wire logic     pop,
  output tgr_cmd_t      pop_data,
  output logic          empty
);

  tgr_cmd_t          entry_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   count_r;
  logic              do_push;
  logic              do_pop;

  assign full     = (count_r == (QPTR_W+1)'(QDEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = entry_r[rd_ptr_r];

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + (QPTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - (QPTR_W+1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/tgr_back.sv -----
// ----------------------------------------------------------------------------
// tgr_back
// Executes commands: writes font bytes into the two-bank font memory and
// walks the scanlines of a rendered cell, one memory read per line.
// ----------------------------------------------------------------------------
`default_nettype none

module tgr_back
  import tgr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  output logic          q_pop,
  input  wire tgr_cmd_t q_data,
  input  wire logic     q_empty,
  output logic          out_valid,
  input  wire logic     out_stall,
  output tgr_out_t      out_data
);

  localparam int BANK_DEPTH = 2 ** BANK_AW;

  // Even bytes in one bank, odd bytes in the other, so a two-byte line
  // comes out in one read.
  logic [7:0] bank_even [BANK_DEPTH];
  logic [7:0] bank_odd  [BANK_DEPTH];
  logic [7:0] rd_even_r;
  logic [7:0] rd_odd_r;

  // Line walker.
  logic               busy_r;
  logic [GH_W-1:0]    line_r;
  logic [GH_W-1:0]    height_r;
  logic [FONT_AW-1:0] gaddr_r;
  logic [PIX_W-1:0]   y_r;
  logic [PIX_W-1:0]   px_r;
  logic               wide_r;
  logic [3:0]         fg_r;
  logic [3:0]         bg_r;

  // Read stage.
  logic             s1_valid_r;
  logic [PIX_W-1:0] s1_px_r;
  logic [PIX_W-1:0] s1_y_r;
  logic             s1_last_r;
  logic             s1_wide_r;
  logic             s1_sel_r;
  logic [3:0]       s1_fg_r;
  logic [3:0]       s1_bg_r;

  logic             out_valid_r;
  tgr_out_t         out_data_r;

  logic             start;
  logic             font_wr;
  logic             last;
  logic             issue;
  logic             s1_move;
  logic [15:0]      bits;

  assign q_pop   = !busy_r && !q_empty;
  assign start   = q_pop && (q_data.kind == CMD_RENDER);
  assign font_wr = q_pop && (q_data.kind == CMD_FONT_WRITE);
  assign last    = (line_r == height_r - GH_W'(1));
  assign s1_move = s1_valid_r && (!out_valid_r || !out_stall);
  assign issue   = busy_r && (!s1_valid_r || s1_move);

  // Font memory banks.
  always_ff @(posedge clk) begin
    if (font_wr && !q_data.font_addr[0]) begin
      bank_even[q_data.font_addr[FONT_AW-1:1]] <= q_data.font_byte;
    end
    if (issue) begin
      rd_even_r <= bank_even[gaddr_r[FONT_AW-1:1]];
    end
  end

  always_ff @(posedge clk) begin
    if (font_wr && q_data.font_addr[0]) begin
      bank_odd[q_data.font_addr[FONT_AW-1:1]] <= q_data.font_byte;
    end
    if (issue) begin
      rd_odd_r <= bank_odd[gaddr_r[FONT_AW-1:1]];
    end
  end

  // Walker control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (issue && last) begin
      busy_r <= 1'b0;
    end
  end

  // Walker payload: load on start, step one line per read.
  always_ff @(posedge clk) begin
    if (start) begin
      line_r   <= '0;
      height_r <= q_data.height;
      gaddr_r  <= q_data.glyph_addr;
      y_r      <= q_data.y_base;
      px_r     <= q_data.pixel_x;
      wide_r   <= q_data.wide;
      fg_r     <= q_data.fg_idx;
      bg_r     <= q_data.bg_idx;
    end else if (issue) begin
      line_r  <= line_r + GH_W'(1);
      gaddr_r <= gaddr_r + (wide_r ? FONT_AW'(2) : FONT_AW'(1));
      y_r     <= y_r + PIX_W'(1);
    end
  end

  // Read stage valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (issue) begin
      s1_valid_r <= 1'b1;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  // Read stage payload.
  always_ff @(posedge clk) begin
    if (issue) begin
      s1_px_r   <= px_r;
      s1_y_r    <= y_r;
      s1_last_r <= last;
      s1_wide_r <= wide_r;
      s1_sel_r  <= gaddr_r[0];
      s1_fg_r   <= fg_r;
      s1_bg_r   <= bg_r;
    end
  end

  // Assemble the line bits from the bank outputs.
  always_comb begin
    if (s1_wide_r) begin
      bits = {rd_even_r, rd_odd_r};
    end else if (s1_sel_r) begin
      bits = {rd_odd_r, 8'h00};
    end else begin
      bits = {rd_even_r, 8'h00};
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_move) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_data_r.pixel_x    <= s1_px_r;
      out_data_r.pixel_y    <= s1_y_r;
      out_data_r.glyph_bits <= bits;
      out_data_r.fg_rgb     <= vga_color(s1_fg_r);
      out_data_r.bg_rgb     <= vga_color(s1_bg_r);
      out_data_r.last_line  <= s1_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
